[rtl/core/nmea_gga_sentence_checker_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the GGA sentence checker
// Shared forms for concurrent assertions on the block's clock and reset.
// ---------------------------------------------------------------------------
`ifndef NMEA_GGA_SENTENCE_CHECKER_MACROS_SVH
`define NMEA_GGA_SENTENCE_CHECKER_MACROS_SVH

// assertion on a given clock, disabled while the active-low reset is low
`define NGGA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ngga assertion failed");

// same, on the block's own clock and reset
`define NGGA_ASSERT_CLK(lbl, prop) `NGGA_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

[rtl/core/ngga_pkg.sv]
// ---------------------------------------------------------------------------
// GGA sentence checker package
// Widths, status codes, character codes and field types shared by the block.
// ---------------------------------------------------------------------------
package ngga_pkg;

    localparam int ACC_WIDTH_DEF   = 24;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int LIMIT_W         = 16;
    localparam int STATUS_W        = 3;
    localparam int OUT_COUNT_W     = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int FIELD_W         = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_HEADER,
        ST_TIME,
        ST_LATITUDE,
        ST_NOT_N,
        ST_LONGITUDE,
        ST_NOT_E,
        ST_NO_DIGITS
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LINE
    } t_phase;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_LAT_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LON_LIMIT = 2'd1;

    localparam logic [LIMIT_W-1:0] LAT_LIMIT_RST = 16'd9000;
    localparam logic [LIMIT_W-1:0] LON_LIMIT_RST = 16'd18000;

    // field positions within a sentence
    localparam logic [FIELD_W-1:0] FLD_HEADER = 3'd0;
    localparam logic [FIELD_W-1:0] FLD_TIME   = 3'd1;
    localparam logic [FIELD_W-1:0] FLD_LAT    = 3'd2;
    localparam logic [FIELD_W-1:0] FLD_NS     = 3'd3;
    localparam logic [FIELD_W-1:0] FLD_LON    = 3'd4;
    localparam logic [FIELD_W-1:0] FLD_EW     = 3'd5;
    localparam logic [FIELD_W-1:0] FLD_LAST   = 3'd7;

    localparam logic [FIELD_W-1:0] HDR_LEN    = 3'd6;
    localparam logic [FIELD_W-1:0] CIF_MAX    = 3'd7;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_VT     = 8'h0B;
    localparam logic [7:0] CHAR_FF     = 8'h0C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_E      = 8'h45;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_A      = 8'h41;

    typedef struct packed {
        logic neg;
        logic dot;
        logic digit;
        logic frac;
        logic ended;
        logic begun;
    } t_num_flags;

    // expected header text "$GPGGA"
    function automatic logic [7:0] hdr_char(input logic [FIELD_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = CHAR_DOLLAR;
            3'd1:    ch = CHAR_G;
            3'd2:    ch = CHAR_P;
            3'd3:    ch = CHAR_G;
            3'd4:    ch = CHAR_G;
            3'd5:    ch = CHAR_A;
            default: ch = CHAR_DOLLAR;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/nmea_gga_sentence_checker.sv]
// ---------------------------------------------------------------------------
// GGA sentence checker
// Parses a serial character stream and reports the status of each GGA line.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  rx      | in        | i_rx_valid / o_rx_ready    | i_rx_byte
//  result  | out       | o_res_valid / i_res_ready  | o_status, o_accepted_count
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One character per cycle sustained; a stalled result holds only a carriage
//  return, other characters keep flowing past it. A character is captured in
//  the input register and parsed from there, and a line result is registered
//  once its carriage return is parsed. The per-character parse is one
//  multiply-by-ten and saturate plus a limit compare. Reset is synchronous and
//  clears all line state and the limits to their defaults.
// ---------------------------------------------------------------------------
module nmea_gga_sentence_checker #(
    parameter int ACC_WIDTH   = ngga_pkg::ACC_WIDTH_DEF,
    parameter int COUNT_WIDTH = ngga_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rx_valid,
    output logic                              o_rx_ready,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [ngga_pkg::STATUS_W-1:0]     o_status,
    output logic [ngga_pkg::OUT_COUNT_W-1:0]  o_accepted_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ngga_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ngga_pkg::LIMIT_W-1:0]      i_cfg_data
);
    import ngga_pkg::*;

    localparam int MulW    = ACC_WIDTH + 4;
    localparam int CntExtW = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    t_phase                 r_phase, n_phase;
    logic [FIELD_W-1:0]     r_field, n_field;
    logic [FIELD_W-1:0]     r_cif, n_cif;
    logic                   r_prev_sep, n_prev_sep;
    t_status                r_err, n_err;
    logic [ACC_WIDTH-1:0]   r_acc, n_acc;
    t_num_flags             r_flags, n_flags;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [LIMIT_W-1:0]     r_lat_lim, r_lon_lim;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [OUT_COUNT_W-1:0] r_out_count, n_out_count;

    logic                   res_gen, out_free, advance;
    logic [7:0]             ch;
    logic                   is_digit, is_ws, is_num_field;
    logic [MulW-1:0]        acc_ext, mul10;
    logic [ACC_WIDTH-1:0]   acc_step, lim_sel;
    t_num_flags             flags_step;
    logic                   val_zero, rng_ok;
    t_status                ef_err, fc_err, line_err;
    logic [CntExtW-1:0]     count_ext;

    assign ch       = r_in_byte;
    assign res_gen  = (r_phase == PH_LINE) && (ch == CHAR_CR);
    assign out_free = !r_out_valid || i_res_ready;
    assign advance  = r_in_valid && (out_free || !res_gen);

    assign o_rx_ready       = !r_in_valid || advance;
    assign o_res_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_accepted_count = r_out_count;
    assign o_cfg_ready      = 1'b1;

    // number parse step for the current character
    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign is_ws    = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_LF) ||
                      (ch == CHAR_VT) || (ch == CHAR_FF);
    assign acc_ext  = MulW'(r_acc);
    assign mul10    = (acc_ext << 3) + (acc_ext << 1) + MulW'(ch[3:0]);

    always_comb begin
        flags_step = r_flags;
        acc_step   = r_acc;
        if (!r_flags.ended) begin
            if (is_digit) begin
                flags_step.digit = 1'b1;
                flags_step.begun = 1'b1;
                if (r_flags.dot) begin
                    if (ch[3:0] != 4'd0) flags_step.frac = 1'b1;
                end else if (|mul10[MulW-1:ACC_WIDTH]) begin
                    acc_step = '1;
                end else begin
                    acc_step = mul10[ACC_WIDTH-1:0];
                end
            end else if ((ch == CHAR_DOT) && !r_flags.dot) begin
                flags_step.dot   = 1'b1;
                flags_step.begun = 1'b1;
            end else if (((ch == CHAR_PLUS) || (ch == CHAR_MINUS)) && !r_flags.begun) begin
                flags_step.begun = 1'b1;
                if (ch == CHAR_MINUS) flags_step.neg = 1'b1;
            end else if (!r_flags.begun && is_ws) begin
                flags_step = r_flags;
            end else begin
                flags_step.ended = 1'b1;
            end
        end
    end

    // range check: value in [0, limit]; negative zero counts as zero
    assign lim_sel  = (r_field == FLD_LAT) ? ACC_WIDTH'(r_lat_lim) : ACC_WIDTH'(r_lon_lim);
    assign val_zero = (r_acc == '0) && !r_flags.frac;
    assign rng_ok   = r_flags.neg ? val_zero
                    : ((r_acc < lim_sel) || ((r_acc == lim_sel) && !r_flags.frac));

    // check made when a field ends
    always_comb begin
        ef_err = ST_OK;
        unique case (r_field)
            FLD_HEADER: if (r_cif < HDR_LEN) ef_err = ST_HEADER;
            FLD_TIME: begin
                if (!r_flags.digit) ef_err = ST_NO_DIGITS;
                else if (r_flags.neg || val_zero) ef_err = ST_TIME;
            end
            FLD_LAT: begin
                if (!r_flags.digit) ef_err = ST_NO_DIGITS;
                else if (!rng_ok) ef_err = ST_LATITUDE;
            end
            FLD_NS: if (r_cif == '0) ef_err = ST_NOT_N;
            FLD_LON: begin
                if (!r_flags.digit) ef_err = ST_NO_DIGITS;
                else if (!rng_ok) ef_err = ST_LONGITUDE;
            end
            FLD_EW: if (r_cif == '0) ef_err = ST_NOT_E;
            default: ef_err = ST_OK;
        endcase
    end

    // check made on each character inside a field
    always_comb begin
        fc_err = ST_OK;
        unique case (r_field)
            FLD_HEADER: if ((r_cif < HDR_LEN) && (ch != hdr_char(r_cif))) fc_err = ST_HEADER;
            FLD_NS:     if ((r_cif == '0) && (ch != CHAR_N)) fc_err = ST_NOT_N;
            FLD_EW:     if ((r_cif == '0) && (ch != CHAR_E)) fc_err = ST_NOT_E;
            default:    fc_err = ST_OK;
        endcase
    end

    assign is_num_field = (r_field == FLD_TIME) || (r_field == FLD_LAT) || (r_field == FLD_LON);
    assign line_err     = (r_err != ST_OK) ? r_err : ef_err;

    always_comb begin
        n_phase      = r_phase;
        n_field      = r_field;
        n_cif        = r_cif;
        n_prev_sep   = r_prev_sep;
        n_err        = r_err;
        n_acc        = r_acc;
        n_flags      = r_flags;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        count_ext    = CntExtW'(r_count);
        if (advance) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (ch == CHAR_DOLLAR) begin
                        // the '$' is the first header character and always matches
                        n_phase    = PH_LINE;
                        n_field    = FLD_HEADER;
                        n_cif      = 3'd1;
                        n_prev_sep = 1'b0;
                        n_err      = ST_OK;
                        n_acc      = '0;
                        n_flags    = '0;
                    end
                end
                PH_LINE: begin
                    if (ch == CHAR_CR) begin
                        if (line_err == ST_OK) n_count = r_count + COUNT_WIDTH'(1);
                        count_ext    = CntExtW'(n_count);
                        n_out_valid  = 1'b1;
                        n_out_status = line_err;
                        n_out_count  = count_ext[OUT_COUNT_W-1:0];
                        n_phase      = PH_IDLE;
                        n_field      = FLD_HEADER;
                        n_cif        = '0;
                        n_prev_sep   = 1'b0;
                        n_err        = ST_OK;
                        n_acc        = '0;
                        n_flags      = '0;
                    end else if (ch == CHAR_COMMA) begin
                        // a run of commas is one separator
                        if (!r_prev_sep) begin
                            n_err      = line_err;
                            n_field    = (r_field == FLD_LAST) ? FLD_LAST : r_field + 3'd1;
                            n_cif      = '0;
                            n_acc      = '0;
                            n_flags    = '0;
                            n_prev_sep = 1'b1;
                        end
                    end else begin
                        n_prev_sep = 1'b0;
                        if (r_err == ST_OK) n_err = fc_err;
                        if (is_num_field) begin
                            n_acc   = acc_step;
                            n_flags = flags_step;
                        end
                        if (r_cif != CIF_MAX) n_cif = r_cif + 3'd1;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_field     <= FLD_HEADER;
            r_cif       <= '0;
            r_prev_sep  <= 1'b0;
            r_err       <= ST_OK;
            r_acc       <= '0;
            r_flags     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_lat_lim   <= LAT_LIMIT_RST;
            r_lon_lim   <= LON_LIMIT_RST;
        end else begin
            if (o_rx_ready) r_in_valid <= i_rx_valid;
            r_field     <= n_field;
            r_cif       <= n_cif;
            r_prev_sep  <= n_prev_sep;
            r_err       <= n_err;
            r_acc       <= n_acc;
            r_flags     <= n_flags;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && (i_cfg_index == REG_LAT_LIMIT)) r_lat_lim <= i_cfg_data;
            if (i_cfg_valid && (i_cfg_index == REG_LON_LIMIT)) r_lon_lim <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) r_in_byte <= i_rx_byte;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

endmodule

[rtl/core/ngga_checker.sv]
// ---------------------------------------------------------------------------
// GGA sentence checker port assertions
// Watches the top-level ports for result ordering and count consistency.
// ---------------------------------------------------------------------------
`include "nmea_gga_sentence_checker_macros.svh"

module ngga_checker #(
    parameter int COUNT_WIDTH = ngga_pkg::COUNT_WIDTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_rx_valid,
    input logic                              o_rx_ready,
    input logic [7:0]                        i_rx_byte,
    input logic                              o_res_valid,
    input logic                              i_res_ready,
    input logic [ngga_pkg::STATUS_W-1:0]     o_status,
    input logic [ngga_pkg::OUT_COUNT_W-1:0]  o_accepted_count
);
    import ngga_pkg::*;

    localparam int             CntWrap = (COUNT_WIDTH >= OUT_COUNT_W) ? OUT_COUNT_W : COUNT_WIDTH;
    localparam logic [OUT_COUNT_W:0] CntMask = (17'd1 << CntWrap) - 17'd1;

    logic [OUT_COUNT_W-1:0] r_last_cnt;
    logic [OUT_COUNT_W-1:0] next_cnt;
    logic                   res_take;

    assign res_take = o_res_valid && i_res_ready;
    assign next_cnt = (r_last_cnt + 16'd1) & CntMask[OUT_COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt <= '0;
        end else if (res_take) begin
            r_last_cnt <= o_accepted_count;
        end
    end

    // a stalled result request holds
    `NGGA_ASSERT_CLK(a_res_hold, o_res_valid && !i_res_ready |=>
        o_res_valid && $stable(o_status) && $stable(o_accepted_count))

    // an accepted line advances the count by one, a failed one leaves it
    `NGGA_ASSERT_CLK(a_ok_count, res_take && (o_status == ST_OK) |-> o_accepted_count == next_cnt)
    `NGGA_ASSERT_CLK(a_err_count, res_take && (o_status != ST_OK) |-> o_accepted_count == r_last_cnt)

    // a fresh result follows a carriage return taken at the rx port, through the input and result registers
    `NGGA_ASSERT_CLK(a_res_cause, $rose(o_res_valid) |->
        $past(i_rx_valid && o_rx_ready && (i_rx_byte == CHAR_CR), 2))

    // with no result pending the input side never stalls
    `NGGA_ASSERT_CLK(a_rx_free, !o_res_valid |-> o_rx_ready)

endmodule

bind nmea_gga_sentence_checker ngga_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_ngga_checker (.*);

[bench/nmea_gga_sentence_checker_tb.sv]
// ---------------------------------------------------------------------------
// GGA sentence checker testbench
// Feeds directed and randomised NMEA character streams through the rx
// channel and changes the limit registers between runs. Each line verdict is
// predicted per character and compared with the result channel in order.
// ---------------------------------------------------------------------------
module nmea_gga_sentence_checker_tb;
    import ngga_pkg::*;

    localparam int          ACC_W          = ACC_WIDTH_DEF;
    localparam logic [63:0] ACC_MAX        = (64'd1 << ACC_W) - 64'd1;
    localparam logic [47:0] GGA_TAG        = "$GPGGA";
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          MAX_REPORTS    = 10;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_W = 8'h57;

    typedef struct packed {
        t_status                 status;
        logic [OUT_COUNT_W-1:0]  count;
    } t_line_verdict;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0]  index;
        logic [LIMIT_W-1:0]      data;
    } t_reg_write;

    logic                       i_clk            = 1'b0;
    logic                       i_rst_n          = 1'b0;
    logic                       i_rx_valid       = 1'b0;
    logic [7:0]                 i_rx_byte        = 8'h00;
    logic                       i_res_ready      = 1'b0;
    logic                       i_cfg_valid      = 1'b0;
    logic [CFG_INDEX_W-1:0]     i_cfg_index      = REG_LAT_LIMIT;
    logic [LIMIT_W-1:0]         i_cfg_data       = '0;
    logic                       o_rx_ready;
    logic                       o_res_valid;
    logic [STATUS_W-1:0]        o_status;
    logic [OUT_COUNT_W-1:0]     o_accepted_count;
    logic                       o_cfg_ready;

    logic [7:0]     rx_pending_q[$];
    t_reg_write     reg_writes_q[$];
    t_line_verdict  line_verdicts_q[$];

    logic [7:0]     blanks[5] = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF};

    int unsigned    src_gap_pct    = 0;
    int unsigned    sink_stall_pct = 0;
    int unsigned    queued_chars   = 0;
    int unsigned    chars_sent     = 0;
    int unsigned    regs_issued    = 0;
    int unsigned    regs_done      = 0;
    int unsigned    lines_checked  = 0;
    int unsigned    mismatches     = 0;
    int unsigned    quiet_cycles   = 0;
    bit             rx_fire        = 1'b0;
    bit             cfg_fire       = 1'b0;

    // predictor state
    t_phase                 line_ph  = PH_IDLE;
    logic [FIELD_W-1:0]     fld      = FLD_HEADER;
    logic [FIELD_W-1:0]     cif      = '0;
    logic                   sep_seen = 1'b0;
    t_status                err      = ST_OK;
    logic [63:0]            acc      = '0;
    t_num_flags             nf       = '0;
    logic [OUT_COUNT_W-1:0] ok_lines = '0;
    logic [LIMIT_W-1:0]     lat_lim  = LAT_LIMIT_RST;
    logic [LIMIT_W-1:0]     lon_lim  = LON_LIMIT_RST;

    nmea_gga_sentence_checker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_status         (o_status),
        .o_accepted_count (o_accepted_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- line verdict prediction ----------------

    function automatic void flag_error(input t_status code);
        if (err == ST_OK) err = code;
    endfunction

    function automatic void fresh_field();
        cif = '0;
        acc = '0;
        nf  = '0;
    endfunction

    function automatic void number_char(input logic [7:0] ch);
        logic [63:0] grown;
        if (nf.ended) begin
            // rest of the field ignored
        end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            nf.digit = 1'b1;
            nf.begun = 1'b1;
            if (nf.dot) begin
                if (ch != CHAR_ZERO) nf.frac = 1'b1;
            end else begin
                grown = acc * 64'd10 + 64'(ch - CHAR_ZERO);
                acc   = (grown > ACC_MAX) ? ACC_MAX : grown;
            end
        end else if (ch == CHAR_DOT && !nf.dot) begin
            nf.dot   = 1'b1;
            nf.begun = 1'b1;
        end else if ((ch == CHAR_PLUS || ch == CHAR_MINUS) && !nf.begun) begin
            nf.begun = 1'b1;
            if (ch == CHAR_MINUS) nf.neg = 1'b1;
        end else if (!nf.begun && (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_LF ||
                                   ch == CHAR_VT || ch == CHAR_FF)) begin
            // leading blanks skipped
        end else begin
            nf.ended = 1'b1;
        end
    endfunction

    // value within [0, lim]; negative zero passes
    function automatic bit within_limit(input logic [LIMIT_W-1:0] lim);
        bit is_zero;
        is_zero = (acc == 0) && !nf.frac;
        if (nf.neg) return is_zero;
        if (acc < 64'(lim)) return 1'b1;
        return (acc == 64'(lim)) && !nf.frac;
    endfunction

    function automatic void close_field();
        case (fld)
            FLD_HEADER: if (cif < HDR_LEN) flag_error(ST_HEADER);
            FLD_TIME: begin
                if (!nf.digit) flag_error(ST_NO_DIGITS);
                else if (nf.neg || (acc == 0 && !nf.frac)) flag_error(ST_TIME);
            end
            FLD_LAT: begin
                if (!nf.digit) flag_error(ST_NO_DIGITS);
                else if (!within_limit(lat_lim)) flag_error(ST_LATITUDE);
            end
            FLD_NS: if (cif == 0) flag_error(ST_NOT_N);
            FLD_LON: begin
                if (!nf.digit) flag_error(ST_NO_DIGITS);
                else if (!within_limit(lon_lim)) flag_error(ST_LONGITUDE);
            end
            FLD_EW: if (cif == 0) flag_error(ST_NOT_E);
            default: ;
        endcase
    endfunction

    function automatic void field_char(input logic [7:0] ch);
        case (fld)
            FLD_HEADER: begin
                if (cif < HDR_LEN && ch != GGA_TAG[47 - 8 * int'(cif) -: 8])
                    flag_error(ST_HEADER);
            end
            FLD_TIME, FLD_LAT, FLD_LON: number_char(ch);
            FLD_NS: if (cif == 0 && ch != CHAR_N) flag_error(ST_NOT_N);
            FLD_EW: if (cif == 0 && ch != CHAR_E) flag_error(ST_NOT_E);
            default: ;
        endcase
        if (cif < CIF_MAX) cif++;
    endfunction

    function automatic void parse_char(input logic [7:0] ch);
        t_line_verdict verdict;
        if (line_ph == PH_IDLE) begin
            if (ch == CHAR_DOLLAR) begin
                line_ph  = PH_LINE;
                fld      = FLD_HEADER;
                sep_seen = 1'b0;
                err      = ST_OK;
                fresh_field();
                field_char(ch);
            end
        end else if (ch == CHAR_CR) begin
            close_field();
            if (err == ST_OK) ok_lines++;
            verdict.status = err;
            verdict.count  = ok_lines;
            line_verdicts_q.push_back(verdict);
            line_ph  = PH_IDLE;
            fld      = FLD_HEADER;
            sep_seen = 1'b0;
            err      = ST_OK;
            fresh_field();
        end else if (ch == CHAR_COMMA) begin
            // comma runs collapse into one separator
            if (!sep_seen) begin
                close_field();
                if (fld < FLD_LAST) fld++;
                fresh_field();
                sep_seen = 1'b1;
            end
        end else begin
            sep_seen = 1'b0;
            field_char(ch);
        end
    endfunction

    // ---------------- handshakes, prediction and watchdog ----------------

    always @(posedge i_clk) begin
        rx_fire  = i_rst_n && i_rx_valid && o_rx_ready;
        cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (rx_fire) begin
            parse_char(i_rx_byte);
            chars_sent++;
        end
        if (cfg_fire) begin
            if (i_cfg_index == REG_LAT_LIMIT) lat_lim = i_cfg_data;
            else if (i_cfg_index == REG_LON_LIMIT) lon_lim = i_cfg_data;
            regs_done++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (i_cfg_valid && o_cfg_ready) ||
            (o_res_valid && i_res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("nmea_gga_sentence_checker_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- drivers ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || rx_fire) begin
            if (rx_pending_q.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
                i_rx_byte  <= rx_pending_q.pop_front();
                i_rx_valid <= 1'b1;
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : reg_driver
        t_reg_write wr;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (!i_cfg_valid || cfg_fire) begin
            if (reg_writes_q.size() != 0) begin
                wr = reg_writes_q.pop_front();
                i_cfg_index <= wr.index;
                i_cfg_data  <= wr.data;
                i_cfg_valid <= 1'b1;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_res_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ---------------- result checking ----------------

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
    endtask

    always @(posedge i_clk) begin : verdict_check
        t_line_verdict want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (line_verdicts_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d count %0d",
                                          o_status, o_accepted_count));
            end else begin
                want = line_verdicts_q.pop_front();
                if (o_status != want.status || o_accepted_count != want.count)
                    report_mismatch($sformatf("status exp %0d got %0d, count exp %0d got %0d",
                                              want.status, o_status, want.count,
                                              o_accepted_count));
                lines_checked++;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic put_byte(input logic [7:0] ch);
        rx_pending_q.push_back(ch);
        queued_chars++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_line(input string s);
        put_text(s);
        put_byte(CHAR_CR);
    endtask

    // number clustered around its limit, with signs, blanks, fractions and junk
    task automatic put_number(input int unsigned lim);
        int unsigned val;
        case ($urandom_range(0, 11))
            0:       val = 0;
            1:       val = lim;
            2:       val = lim + 1;
            3:       val = (lim > 0) ? lim - 1 : 0;
            4:       val = $urandom_range(16777000, 99999999);
            default: val = $urandom_range(0, lim + lim / 4 + 2);
        endcase
        if ($urandom_range(0, 7) == 0) put_byte(blanks[$urandom_range(0, 4)]);
        case ($urandom_range(0, 9))
            0:       put_byte(CHAR_MINUS);
            1:       put_byte(CHAR_PLUS);
            default: ;
        endcase
        if ($urandom_range(0, 15) != 0) begin
            if ($urandom_range(0, 5) == 0) put_byte(CHAR_ZERO);
            put_text($sformatf("%0d", val));
        end
        case ($urandom_range(0, 5))
            0:       put_byte(CHAR_DOT);
            1:       put_text(".000");
            2:       put_text($sformatf(".%0d", $urandom_range(1, 999)));
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic put_hemisphere(input logic [7:0] good, input logic [7:0] other);
        case ($urandom_range(0, 7))
            0:       put_byte(8'($urandom_range(0, 255)));
            1:       put_byte(other);
            2:       ;
            3: begin
                put_byte(good);
                put_text("th");
            end
            default: put_byte(good);
        endcase
    endtask

    task automatic put_random_line();
        int unsigned nfld;
        logic [7:0]  junk;
        // stray characters between lines
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                junk = 8'($urandom_range(0, 255));
                put_byte((junk == CHAR_DOLLAR) ? 8'hA4 : junk);
            end
        end
        case ($urandom_range(0, 15))
            0: put_text("$");
            1: put_text("$GPG");
            2: begin
                put_text("$GPG");
                put_byte(8'($urandom_range(0, 255)));
                put_text("A");
            end
            3:       put_text("$GPGGAXY");
            default: put_text("$GPGGA");
        endcase
        nfld = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : $urandom_range(5, 9);
        for (int f = 1; f <= nfld; f++) begin
            put_byte(CHAR_COMMA);
            if ($urandom_range(0, 11) == 0) put_byte(CHAR_COMMA);
            case (f)
                1:       put_number(235959);
                2:       put_number(32'(lat_lim));
                3:       put_hemisphere(CHAR_N, CHAR_S);
                4:       put_number(32'(lon_lim));
                5:       put_hemisphere(CHAR_E, CHAR_W);
                default: put_text($sformatf("%0d", $urandom_range(0, 99)));
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) put_byte(CHAR_COMMA);
        put_byte(CHAR_CR);
    endtask

    // all characters taken, all verdicts in, then let the pipeline drain
    task automatic wait_quiet();
        while (chars_sent != queued_chars || line_verdicts_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [LIMIT_W-1:0] data);
        t_reg_write wr;
        wr.index = idx;
        wr.data  = data;
        reg_writes_q.push_back(wr);
        regs_issued++;
    endtask

    task automatic set_limits(input logic [LIMIT_W-1:0] lat, input logic [LIMIT_W-1:0] lon);
        write_reg(REG_LAT_LIMIT, lat);
        write_reg(REG_LON_LIMIT, lon);
        while (regs_done != regs_issued) @(negedge i_clk);
    endtask

    task automatic run_random(input int unsigned gap, input int unsigned stall,
                              input int unsigned nchars);
        int unsigned goal;
        src_gap_pct    = gap;
        sink_stall_pct = stall;
        goal = queued_chars + nchars;
        while (queued_chars < goal) put_random_line();
        wait_quiet();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_gap_pct    = 25;
        sink_stall_pct = 75;
        put_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
        put_line("$GPGGB,1,1,N,1,E");
        put_line("$GP");
        put_line("$GPGGA,-0.0,1,N,1,E");
        put_line("$GPGGA,0.5,9000,N,18000,E");
        put_line("$GPGGA,1,9000.01,N,1,E");
        put_line("$GPGGA,1,-0,N,-0.000,E");
        put_line("$GPGGA,1,-1,N,1,E");
        put_line("$GPGGA,1, \t\n\v\f+12,S,1,E");
        put_line("$GPGGA,1,1,N,18001,W");
        put_line("$GPGGA,1,1,N,1,W");
        put_line("$GPGGA,1,1,");
        put_line("$GPGGA,1,1,N,1,");
        put_line("$GPGGA");
        put_line("$GPGGA,");
        put_line("$GPGGA,.,1,N,1,E");
        put_line("$GPGGA,$12,1,N,1,E");
        put_line("$GPGGA,1,99999999999,N,1,E");
        put_line("$GPGGAXYZXYZ,,,1.2.3,,4+5,N,,6e3,EAST,7,8,9,10");
        put_line("$$GPGGA,1,1,N,1,E");
        // characters outside a line, a lone carriage return among them
        put_text("noise 123\n,,");
        put_byte(CHAR_CR);
        put_byte(8'hFF);
        put_line("$GPGGB,0,99999,S,99999,W");
        put_line("$GPGGA,abc,1,N,1,E");
        put_line("$GPGGA,+7,,,,1,,,N,,,1,,,E");
        wait_quiet();

        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'($urandom_range(0, 65535)));
        set_limits(16'd0, 16'd0);
        run_random(25, 75, 400);

        set_limits(16'hFFFF, 16'hFFFF);
        run_random(75, 25, 400);

        set_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 20000)));
        run_random(0, 0, 400);

        $display("%0d characters parsed, %0d line verdicts checked, %0d register writes",
                 chars_sent, lines_checked, regs_done);
        $display("limits at reset, zero, full scale and random; mixed and no idling");
        if (mismatches == 0 && line_verdicts_q.size() == 0) begin
            $display("nmea_gga_sentence_checker_tb OK");
        end else begin
            $display("nmea_gga_sentence_checker_tb NOT OK");
        end
        $finish;
    end

endmodule

[nmea_gga_sentence_checker.f]
+incdir+rtl/core
rtl/core/ngga_pkg.sv
rtl/core/nmea_gga_sentence_checker.sv
rtl/core/ngga_checker.sv
bench/nmea_gga_sentence_checker_tb.sv
